// ===== src/i2c_accelerometer_register_target_macros.svh =====
// Assertion macros used by the checker file.
`ifndef I2C_ACCELEROMETER_REGISTER_TARGET_MACROS_SVH
`define I2C_ACCELEROMETER_REGISTER_TARGET_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define IART_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define IART_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/iart_pkg.sv =====
// Shared constants, types and functions of the accelerometer register target.
package iart_pkg;

    localparam int REG_COUNT = 64;
    localparam int PTR_W     = $clog2(REG_COUNT);

    // Bus event kinds
    localparam logic [1:0] REQ_CONNECT = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_WRITE   = 2'd2;
    localparam logic [1:0] REQ_STOP    = 2'd3;

    // Fixed values and register addresses
    localparam logic [6:0]       DEV_ADDR_RESET = 7'h53;
    localparam logic [7:0]       ID_VALUE       = 8'hE5;
    localparam logic [7:0]       FORMAT_VALUE   = 8'h08;
    localparam logic [7:0]       POWER_RESET    = 8'h08;
    localparam logic [PTR_W-1:0] ADDR_ID        = PTR_W'(8'h00);
    localparam logic [PTR_W-1:0] ADDR_POWER     = PTR_W'(8'h2D);
    localparam logic [PTR_W-1:0] ADDR_FORMAT    = PTR_W'(8'h31);
    localparam logic [PTR_W-1:0] ADDR_X_LOW     = PTR_W'(8'h32);
    localparam logic [PTR_W-1:0] ADDR_X_HIGH    = PTR_W'(8'h33);
    localparam logic [PTR_W-1:0] ADDR_Y_LOW     = PTR_W'(8'h34);
    localparam logic [PTR_W-1:0] ADDR_Y_HIGH    = PTR_W'(8'h35);
    localparam logic [PTR_W-1:0] ADDR_Z_LOW     = PTR_W'(8'h36);
    localparam logic [PTR_W-1:0] ADDR_Z_HIGH    = PTR_W'(8'h37);

    // One captured bus event
    typedef struct packed {
        logic [1:0]         req_type;
        logic [6:0]         bus_address;
        logic               is_read;
        logic [7:0]         write_data;
        logic signed [15:0] x_sample;
        logic signed [15:0] y_sample;
        logic signed [15:0] z_sample;
    } t_req;

    // Store write request
    typedef struct packed {
        logic             en;
        logic [PTR_W-1:0] addr;
        logic [7:0]       data;
    } t_wr_req;

    // Value an entry holds until first written
    function automatic logic [7:0] f_store_reset(input logic [PTR_W-1:0] addr);
        logic [7:0] v;
        case (addr)
            ADDR_ID:     v = ID_VALUE;
            ADDR_POWER:  v = POWER_RESET;
            ADDR_FORMAT: v = FORMAT_VALUE;
            default:     v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== src/iart_req_if.sv =====
// Bus event channel: valid/ready handshake with one event word.
interface iart_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [6:0]         bus_address;
    logic               is_read;
    logic [7:0]         write_data;
    logic signed [15:0] x_sample;
    logic signed [15:0] y_sample;
    logic signed [15:0] z_sample;

    modport source (
        output valid, req_type, bus_address, is_read, write_data,
               x_sample, y_sample, z_sample,
        input  ready
    );
    modport sink (
        input  valid, req_type, bus_address, is_read, write_data,
               x_sample, y_sample, z_sample,
        output ready
    );
endinterface

// ===== src/iart_rsp_if.sv =====
// Result channel: valid/ready handshake with ack and read byte.
interface iart_rsp_if;
    logic       valid;
    logic       ready;
    logic       ack;
    logic [7:0] read_data;

    modport source (
        output valid, ack, read_data,
        input  ready
    );
    modport sink (
        input  valid, ack, read_data,
        output ready
    );
endinterface

// ===== src/i2c_accelerometer_register_target.sv =====
// Top level of the accelerometer register target.
//
// Usage:
//   i_req carries one bus event per word: connect, read byte, write byte or
//   stop, together with the current x, y and z samples. o_rsp returns one
//   word per event: ack and the read byte (zero for anything but a read).
//   The APB port sets the acknowledged seven-bit bus address at offset 0.
//
// Timing:
//   An event is taken, the store is read at the pointer in that same edge,
//   and the result word is registered in the cycle after. No new event is
//   taken while one is in flight, so the store read and the write-back of
//   one event finish before the next event begins.
//
// Reset clears the pointer, the load flag and the store's valid bits, so
// every entry reads its power-on value at once; i_req.ready is low in reset.
// If o_rsp is stalled, the result word holds and i_req.ready stays low until
// it is taken (the event that frees it may be taken in the same cycle).
module i2c_accelerometer_register_target (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iart_req_if.sink    i_req,
    iart_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0]                     dev_addr;
    logic                           in_fire;
    logic                           r_busy;
    iart_pkg::t_req                 r_item;
    logic [iart_pkg::PTR_W-1:0]     r_ptr;
    logic [iart_pkg::PTR_W-1:0]     n_ptr;
    logic                           r_pend;
    logic                           n_pend;
    logic                           r_out_valid;
    logic                           r_out_ack;
    logic [7:0]                     r_out_data;
    logic                           n_ack;
    logic [7:0]                     n_data;
    logic [7:0]                     store_data;
    iart_pkg::t_wr_req              wr;

    iart_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_dev_addr (dev_addr)
    );

    iart_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_fire),
        .i_rd_addr (r_ptr),
        .o_rd_data (store_data),
        .i_wr      (wr)
    );

    // Take a word only out of reset, with no event in flight and the output able to drain
    assign i_req.ready = i_rst_n && !r_busy && (!r_out_valid || o_rsp.ready);
    assign in_fire     = i_req.valid && i_req.ready;

    // Capture the event
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item.req_type    <= i_req.req_type;
            r_item.bus_address <= i_req.bus_address;
            r_item.is_read     <= i_req.is_read;
            r_item.write_data  <= i_req.write_data;
            r_item.x_sample    <= i_req.x_sample;
            r_item.y_sample    <= i_req.y_sample;
            r_item.z_sample    <= i_req.z_sample;
        end
    end

    // Resolve the event against the store word read at the pointer
    always_comb begin
        n_ack   = 1'b1;
        n_data  = 8'd0;
        n_ptr   = r_ptr;
        n_pend  = r_pend;
        wr.en   = 1'b0;
        wr.addr = r_ptr;
        wr.data = r_item.write_data;
        case (r_item.req_type)
            iart_pkg::REQ_CONNECT: begin
                if (r_item.bus_address != dev_addr) begin
                    n_ack = 1'b0;
                end else if (!r_item.is_read) begin
                    n_pend = 1'b1;
                end
            end
            iart_pkg::REQ_READ: begin
                case (r_ptr)
                    iart_pkg::ADDR_ID:     n_data = iart_pkg::ID_VALUE;
                    iart_pkg::ADDR_FORMAT: n_data = iart_pkg::FORMAT_VALUE;
                    iart_pkg::ADDR_X_LOW:  n_data = r_item.x_sample[7:0];
                    iart_pkg::ADDR_X_HIGH: n_data = r_item.x_sample[15:8];
                    iart_pkg::ADDR_Y_LOW:  n_data = r_item.y_sample[7:0];
                    iart_pkg::ADDR_Y_HIGH: n_data = r_item.y_sample[15:8];
                    iart_pkg::ADDR_Z_LOW:  n_data = r_item.z_sample[7:0];
                    iart_pkg::ADDR_Z_HIGH: n_data = r_item.z_sample[15:8];
                    default:               n_data = store_data;
                endcase
                n_ptr = r_ptr + 1'b1;
            end
            iart_pkg::REQ_WRITE: begin
                if (r_pend) begin
                    n_ptr  = r_item.write_data[iart_pkg::PTR_W-1:0];
                    n_pend = 1'b0;
                end else begin
                    wr.en = r_busy;
                    n_ptr = r_ptr + 1'b1;
                end
            end
            default: begin
                n_pend = 1'b1;
            end
        endcase
    end

    // Mark an event in flight, advance control state when it completes, clear a taken result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_busy) begin
                r_busy      <= 1'b0;
                r_ptr       <= n_ptr;
                r_pend      <= n_pend;
                r_out_valid <= 1'b1;
            end else begin
                r_busy <= in_fire;
                if (o_rsp.ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_out_ack  <= n_ack;
            r_out_data <= n_data;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.ack       = r_out_ack;
    assign o_rsp.read_data = r_out_data;

endmodule

// ===== src/iart_cfg.sv =====
// APB register block holding the device bus address.
module iart_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [6:0]  o_dev_addr
);

    logic [6:0] r_dev_addr;
    logic       wr_hit;

    // Decode a write to the word at offset zero
    assign wr_hit = psel && penable && pwrite && !paddr[2];

    // Hold the device address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= iart_pkg::DEV_ADDR_RESET;
        end else if (wr_hit) begin
            r_dev_addr <= pwdata[6:0];
        end
    end

    // Read back the register, zero beyond it
    always_comb begin
        if (!paddr[2]) begin
            prdata = {25'd0, r_dev_addr};
        end else begin
            prdata = 32'd0;
        end
    end

    assign pready     = 1'b1;
    assign o_dev_addr = r_dev_addr;

endmodule

// ===== src/iart_regfile.sv =====
// 64-byte register store: registered read, one write port, per-entry valid bits.
module iart_regfile (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [iart_pkg::PTR_W-1:0]   i_rd_addr,
    output logic [7:0]                   o_rd_data,
    input  iart_pkg::t_wr_req            i_wr
);

    logic [7:0]                    r_mem [iart_pkg::REG_COUNT];
    logic [iart_pkg::REG_COUNT-1:0] r_vld;
    logic [7:0]                    r_rd_data;
    logic [7:0]                    r_rd_rst;
    logic                          r_rd_vld;

    // Write the array
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Mark written entries, clear all on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    // Register the read word and its reset fallback
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_vld  <= r_vld[i_rd_addr];
            r_rd_rst  <= iart_pkg::f_store_reset(i_rd_addr);
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : r_rd_rst;

endmodule

// ===== src/iart_checker.sv =====
// Port-level checks of the accelerometer register target and their bind.
`include "i2c_accelerometer_register_target_macros.svh"

module iart_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_ack,
    input logic [7:0] i_out_data
);

    logic in_fire;

    assign in_fire = i_in_valid && i_in_ready;

    // A pending result word stays until taken
    `IART_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result word dropped")

    // One event at a time: no word is taken right after another
    `IART_ASSERT_NEXT(a_one_at_a_time, in_fire, !i_in_ready, "event taken while busy")

    // Every accepted event is followed by a result word
    `IART_ASSERT_NEXT(a_result_follows, in_fire, ##1 i_out_valid, "missing result word")

    // A refused connect returns no data
    `IART_ASSERT_NOW(a_nack_no_data, i_out_valid && !i_out_ack, i_out_data == 8'd0, "nack with data")

endmodule

bind i2c_accelerometer_register_target iart_checker u_iart_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_ack   (o_rsp.ack),
    .i_out_data  (o_rsp.read_data)
);
